@@ sv/keypad_passcode_lock_top_defines.svh @@
// assertion macros for the keypad passcode lock
// expects clk and rst in the scope where a macro is used
`ifndef KEYPAD_PASSCODE_LOCK_TOP_DEFINES_SVH
`define KEYPAD_PASSCODE_LOCK_TOP_DEFINES_SVH

// antecedent holds in this cycle, consequent in the same cycle
`define KPL_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds in this cycle, consequent in the next cycle
`define KPL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/kpl_pkg.sv @@
// shared types and constants for the keypad passcode lock
// no dependencies
`timescale 1ns / 1ps

package kpl_pkg;

  localparam int KEY_W       = 4;
  localparam int LINES_W     = 4;
  localparam int STATUS_W    = 3;
  localparam int ECOUNT_W    = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int PASS_LOW_W  = 64;
  localparam int PASS_HIGH_W = 16;
  localparam int PASS_LEN_W  = 5;

  // passcode register holds this many digit positions
  localparam int PASS_POSITIONS = 20;

  localparam int MAX_DIGITS_DEF  = 20;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [KEY_W-1:0] KEY_STAR  = 4'd12;
  localparam logic [KEY_W-1:0] KEY_POUND = 4'd14;

  localparam logic [PASS_LOW_W-1:0]  PASS_LOW_RST  = 64'd12005904;
  localparam logic [PASS_HIGH_W-1:0] PASS_HIGH_RST = 16'd0;
  localparam logic [PASS_LEN_W-1:0]  PASS_LEN_RST  = 5'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_PASS_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_LEN  = 2'd2;

  typedef enum logic [1:0] {
    OP_STORE,
    OP_CLEAR,
    OP_CHECK
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED   = 3'd0,
    ST_CLEARED  = 3'd1,
    ST_MATCH    = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
  } job_t;

  typedef struct packed {
    logic [PASS_HIGH_W-1:0] high;
    logic [PASS_LOW_W-1:0]  low;
    logic [PASS_LEN_W-1:0]  length;
  } passcode_t;

endpackage

@@ sv/kpl_if.sv @@
// valid/ready channel interfaces for key presses and results
// depends on kpl_pkg
`timescale 1ns / 1ps

interface kpl_key_if;
  logic                        valid;
  logic                        ready;
  logic [kpl_pkg::LINES_W-1:0] column_lines;
  logic [kpl_pkg::LINES_W-1:0] row_lines;

  modport source (output valid, output column_lines, output row_lines, input ready);
  modport sink (input valid, input column_lines, input row_lines, output ready);
endinterface

interface kpl_result_if;
  logic                         valid;
  logic                         ready;
  logic [kpl_pkg::STATUS_W-1:0] status;
  logic [kpl_pkg::KEY_W-1:0]    key_index;
  logic [kpl_pkg::ECOUNT_W-1:0] entered_count;

  modport source (output valid, output status, output key_index, output entered_count,
                  input ready);
  modport sink (input valid, input status, input key_index, input entered_count,
                output ready);
endinterface

@@ sv/keypad_passcode_lock_top.sv @@
// keypad passcode lock: key beats pass the job queue and the result register;
// throughput one key beat per cycle while results drain, set by the back end compare
// the two-entry job queue and the result register let input and output stall apart
// reset (rst, synchronous, active high) empties the queue and the entry, drops any
// pending result and loads the passcode registers with their reset values
// depends on kpl_pkg, kpl_if, kpl_front, kpl_fifo and kpl_back
`timescale 1ns / 1ps

module keypad_passcode_lock_top #(
  parameter int MAX_DIGITS  = kpl_pkg::MAX_DIGITS_DEF,
  parameter int QUEUE_DEPTH = kpl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  kpl_key_if.sink                        keys,
  kpl_result_if.source                   result,
  input  logic                           cfg_wr_en,
  input  logic [kpl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kpl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import kpl_pkg::*;

  // passcode registers; the user writes them only while the lock is idle, unchecked
  passcode_t passcode;

  // front to queue
  job_t front_job;
  logic front_push;
  logic queue_full;

  // queue to back
  job_t queue_job;
  logic queue_not_empty;
  logic back_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      passcode.low    <= PASS_LOW_RST;
      passcode.high   <= PASS_HIGH_RST;
      passcode.length <= PASS_LEN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PASS_LOW:  passcode.low    <= cfg_wdata[PASS_LOW_W-1:0];
        CFG_PASS_HIGH: passcode.high   <= cfg_wdata[PASS_HIGH_W-1:0];
        CFG_PASS_LEN:  passcode.length <= cfg_wdata[PASS_LEN_W-1:0];
        // unmapped index, write is ignored
        default: passcode <= passcode;
      endcase
    end
  end

  // decode the matrix lines into a key index and sort the press into a job
  kpl_front u_front (
    .keys       (keys),
    .queue_full (queue_full),
    .push       (front_push),
    .job        (front_job)
  );

  // decoupling queue, the front keeps taking beats while a result waits
  kpl_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_push),
    .push_data (front_job),
    .full      (queue_full),
    .pop       (back_pop),
    .pop_data  (queue_job),
    .not_empty (queue_not_empty)
  );

  // entry store, compare and result register
  kpl_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (queue_job),
    .job_valid (queue_not_empty),
    .job_pop   (back_pop),
    .passcode  (passcode),
    .result    (result)
  );

endmodule

@@ sv/kpl_front.sv @@
// front end: takes key beats, decodes the key index and classifies the press
// depends on kpl_pkg and kpl_if
`timescale 1ns / 1ps

module kpl_front (
  kpl_key_if.sink         keys,
  input  logic            queue_full,
  output logic            push,
  output kpl_pkg::job_t   job
);
  import kpl_pkg::*;

  logic [1:0] col;
  logic [1:0] row;

  // first low line wins, none low gives zero
  always_comb begin
    col = 2'd0;
    for (int i = LINES_W - 1; i >= 0; i--) begin
      if (!keys.column_lines[i]) begin
        col = 2'(i);
      end
    end
    row = 2'd0;
    for (int i = LINES_W - 1; i >= 0; i--) begin
      if (!keys.row_lines[i]) begin
        row = 2'(i);
      end
    end
  end

  always_comb begin
    job.key = {row, col};
    case (job.key)
      KEY_STAR:  job.op = OP_CLEAR;
      KEY_POUND: job.op = OP_CHECK;
      default:   job.op = OP_STORE;
    endcase
  end

  assign keys.ready = !queue_full;
  assign push       = keys.valid && !queue_full;

endmodule

@@ sv/kpl_fifo.sv @@
// short job queue between front and back
// depends on kpl_pkg
`timescale 1ns / 1ps

module kpl_fifo #(
  parameter int DEPTH = kpl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  kpl_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output kpl_pkg::job_t pop_data,
  output logic          not_empty
);
  import kpl_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  logic do_push;
  logic do_pop;

  assign full      = fill == CW'(DEPTH);
  assign not_empty = fill != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

@@ sv/kpl_back.sv @@
// back end: keeps the entered digits, runs clear, store and compare,
// and holds the result register; depends on kpl_pkg, kpl_if and the defines
`timescale 1ns / 1ps
`include "keypad_passcode_lock_top_defines.svh"

module kpl_back #(
  parameter int MAX_DIGITS = kpl_pkg::MAX_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  kpl_pkg::job_t      job,
  input  logic               job_valid,
  output logic               job_pop,
  input  kpl_pkg::passcode_t passcode,
  kpl_result_if.source       result
);
  import kpl_pkg::*;

  localparam int CW  = $clog2(MAX_DIGITS + 1);
  localparam int LW  = (CW > PASS_LEN_W) ? CW : PASS_LEN_W;
  localparam int PAD = (MAX_DIGITS > PASS_POSITIONS) ? MAX_DIGITS : PASS_POSITIONS;

  logic [KEY_W-1:0]     digits [MAX_DIGITS];
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  status_t              status_next;
  logic [4*PAD-1:0]     code_ext;
  logic                 digits_ok;
  logic                 len_ok;
  logic                 is_match;
  logic                 at_limit;
  logic                 store_en;

  assign at_limit = count == CW'(MAX_DIGITS);
  assign store_en = (job.op == OP_STORE) && !at_limit;
  assign job_pop  = job_valid && (!result.valid || result.ready);

  // held digits against passcode, only positions below the count
  always_comb begin
    code_ext  = (4*PAD)'({passcode.high, passcode.low});
    digits_ok = 1'b1;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if ((CW'(i) < count) && (digits[i] != code_ext[4*i +: KEY_W])) begin
        digits_ok = 1'b0;
      end
    end
  end

  assign len_ok   = (passcode.length <= PASS_LEN_W'(PASS_POSITIONS)) &&
                    (LW'(passcode.length) == LW'(count));
  assign is_match = len_ok && digits_ok;

  always_comb begin
    case (job.op)
      OP_CLEAR: begin
        count_next  = '0;
        status_next = ST_CLEARED;
      end
      OP_CHECK: begin
        count_next  = '0;
        status_next = is_match ? ST_MATCH : ST_MISMATCH;
      end
      OP_STORE: begin
        if (at_limit) begin
          count_next  = '0;
          status_next = ST_OVERFLOW;
        end else begin
          count_next  = count + 1'b1;
          status_next = ST_STORED;
        end
      end
      default: begin
        count_next  = count;
        status_next = ST_CLEARED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      result.valid <= 1'b0;
    end else begin
      if (job_pop) begin
        count        <= count_next;
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      result.status        <= status_next;
      result.key_index     <= job.key;
      result.entered_count <= ECOUNT_W'(count_next);
    end
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (job_pop && store_en && (count == CW'(i))) begin
        digits[i] <= job.key;
      end
    end
  end

  `KPL_ASSERT_IMPLY(a_count_bound, 1'b1, count <= CW'(MAX_DIGITS), "entry count past limit")
  `KPL_ASSERT_NEXT(a_store_step, job_pop && store_en, count == $past(count) + 1'b1, "store did not advance count")
  `KPL_ASSERT_NEXT(a_nonstore_empties, job_pop && (job.op != OP_STORE), count == '0, "clear or check kept digits")
  `KPL_ASSERT_NEXT(a_overflow_path, job_pop && (job.op == OP_STORE) && at_limit, (count == '0) && (result.status == ST_OVERFLOW), "overflow not reported")
  `KPL_ASSERT_IMPLY(a_match_cleared, result.valid && (result.status == ST_MATCH), result.entered_count == '0, "match left digits held")

endmodule

@@ dv/kpl_tb_pkg.sv @@
// scoreboard for the keypad passcode lock testbench: predicted outcome of each press
// depends on kpl_pkg
`timescale 1ns / 1ps

package kpl_tb_pkg;
  import kpl_pkg::*;

  localparam int HELD_MAX = MAX_DIGITS_DEF;

  typedef struct {
    status_t                 status;
    logic [KEY_W-1:0]        key;
    logic [ECOUNT_W-1:0]     count;
  } press_outcome_t;

  class lock_scoreboard;
    logic [PASS_LOW_W-1:0]  code_low;
    logic [PASS_HIGH_W-1:0] code_high;
    logic [PASS_LEN_W-1:0]  code_len;
    logic [KEY_W-1:0]       held_digits [HELD_MAX];
    int unsigned            held_count;
    press_outcome_t         awaited_outcomes [$];
    int unsigned            fails;

    function new();
      code_low  = PASS_LOW_RST;
      code_high = PASS_HIGH_RST;
      code_len  = PASS_LEN_RST;
      fails     = 0;
      clear_entry();
    endfunction

    function void clear_entry();
      foreach (held_digits[i]) held_digits[i] = '0;
      held_count = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PASS_LOW:  code_low  = data[PASS_LOW_W-1:0];
        CFG_PASS_HIGH: code_high = data[PASS_HIGH_W-1:0];
        CFG_PASS_LEN:  code_len  = data[PASS_LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [KEY_W-1:0] code_digit(int unsigned pos);
      if (pos < 16) return code_low[4*pos +: 4];
      if (pos < PASS_POSITIONS) return code_high[4*(pos-16) +: 4];
      return '0;
    endfunction

    // lowest line pulled low, none low encodes as zero
    function int unsigned first_low(logic [LINES_W-1:0] lines);
      for (int i = 0; i < LINES_W; i++) begin
        if (!lines[i]) return i;
      end
      return 0;
    endfunction

    function bit entry_matches();
      if (code_len > PASS_POSITIONS) return 1'b0;
      if (held_count != code_len) return 1'b0;
      for (int i = 0; i < held_count; i++) begin
        if (held_digits[i] != code_digit(i)) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_press(logic [LINES_W-1:0] cols, logic [LINES_W-1:0] rows);
      press_outcome_t o;
      o.key = KEY_W'(first_low(cols) + 4 * first_low(rows));
      if (o.key == KEY_STAR) begin
        clear_entry();
        o.status = ST_CLEARED;
      end else if (o.key == KEY_POUND) begin
        o.status = entry_matches() ? ST_MATCH : ST_MISMATCH;
        clear_entry();
      end else if (held_count < HELD_MAX) begin
        held_digits[held_count] = o.key;
        held_count++;
        o.status = ST_STORED;
      end else begin
        clear_entry();
        o.status = ST_OVERFLOW;
      end
      o.count = ECOUNT_W'(held_count);
      awaited_outcomes.push_back(o);
    endfunction

    function void check_outcome(logic [STATUS_W-1:0] status, logic [KEY_W-1:0] key,
                                logic [ECOUNT_W-1:0] count);
      press_outcome_t o;
      if (awaited_outcomes.size() == 0) begin
        $error("result beat with no press outstanding: status %0d key %0d count %0d",
               status, key, count);
        fails++;
        return;
      end
      o = awaited_outcomes.pop_front();
      if (status !== o.status) begin
        $error("status: expected %0d, got %0d", o.status, status);
        fails++;
      end
      if (key !== o.key) begin
        $error("key_index: expected %0d, got %0d", o.key, key);
        fails++;
      end
      if (count !== o.count) begin
        $error("entered_count: expected %0d, got %0d", o.count, count);
        fails++;
      end
    endfunction

    function int unsigned pending();
      return awaited_outcomes.size();
    endfunction
  endclass

endpackage

@@ dv/tb_top.sv @@
// top-level testbench for keypad_passcode_lock_top: key beats in, outcome beats checked
// depends on kpl_pkg, kpl_if, kpl_tb_pkg and the lock rtl
`timescale 1ns / 1ps

module tb_top;
  import kpl_pkg::*;
  import kpl_tb_pkg::*;

  // receiver hold-off long enough to fill the job queue and the result register
  localparam int HOLD_OFF_CYCLES = 60;
  // cycles with no beat and no register write before the run is declared hung
  localparam int STALL_LIMIT     = 1000;
  // settle time after the last result
  localparam int SETTLE_CYCLES   = 8;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  kpl_key_if    keys ();
  kpl_result_if result ();

  lock_scoreboard sb = new();

  int unsigned src_idle_pct  = 16;
  int unsigned sink_idle_pct = 16;
  bit          hold_off_req  = 1'b0;
  int unsigned key_beats     = 0;

  keypad_passcode_lock_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .keys      (keys),
    .result    (result),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // beats are taken at the rising edge, before any register update of that edge
  always @(posedge clk) begin
    if (!rst) begin
      if (keys.valid && keys.ready) sb.note_press(keys.column_lines, keys.row_lines);
      if (result.valid && result.ready) begin
        sb.check_outcome(result.status, result.key_index, result.entered_count);
      end
    end
  end

  // watchdog: counts cycles with nothing moving at all
  initial begin
    int unsigned stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_wr_en || (keys.valid && keys.ready) || (result.valid && result.ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  // result receiver: random back-pressure, plus one long hold-off on request
  initial begin
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        result.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      result.ready = ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // any key index other than star or pound
  function automatic logic [KEY_W-1:0] random_digit();
    logic [KEY_W-1:0] k;
    do k = KEY_W'($urandom_range(0, 15)); while (k == KEY_STAR || k == KEY_POUND);
    return k;
  endfunction

  // lines with bit pos low, lower bits high, upper bits random so they must be ignored
  function automatic logic [LINES_W-1:0] lines_for(int unsigned pos);
    logic [LINES_W-1:0] v;
    v = LINES_W'($urandom_range(0, 15));
    v[pos] = 1'b0;
    for (int i = 0; i < pos; i++) v[i] = 1'b1;
    return v;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  // valid stays high between back-to-back beats
  task automatic send_key(input logic [LINES_W-1:0] cols, input logic [LINES_W-1:0] rows);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      keys.valid = 1'b0;
      @(negedge clk);
    end
    keys.valid        = 1'b1;
    keys.column_lines = cols;
    keys.row_lines    = rows;
    @(posedge clk);
    while (!keys.ready) @(posedge clk);
    key_beats++;
    @(negedge clk);
  endtask

  task automatic press(input logic [KEY_W-1:0] k);
    send_key(lines_for(k % 4), lines_for(k / 4));
  endtask

  // types the first n positions of the programmed passcode
  task automatic enter_code(input int unsigned n);
    for (int i = 0; i < n; i++) press(sb.code_digit(i));
  endtask

  // sender pause: no beat offered until every outcome is back, then let the block settle
  task automatic drain();
    keys.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  // only while idle: after reset or after drain
  task automatic program_code(input logic [CFG_DATA_W-1:0] low,
                              input logic [CFG_DATA_W-1:0] high,
                              input logic [CFG_DATA_W-1:0] len);
    write_reg(CFG_PASS_LOW, low);
    write_reg(CFG_PASS_HIGH, high);
    write_reg(CFG_PASS_LEN, len);
    cfg_wr_en = 1'b0;
  endtask

  // twenty enterable digits packed as the low and high passcode registers
  function automatic logic [79:0] random_code();
    logic [79:0] v;
    for (int i = 0; i < PASS_POSITIONS; i++) v[4*i +: 4] = random_digit();
    return v;
  endfunction

  // mostly well-formed entries ended by pound, some with a slip, some floods and noise
  task automatic random_presses(input int unsigned n);
    int unsigned start, kind, len, bad_pos, i;
    logic [KEY_W-1:0] d;
    start = key_beats;
    while (key_beats - start < n) begin
      kind = $urandom_range(0, 99);
      len  = sb.code_len;
      // a length beyond twenty can never be typed, so aim somewhere in range
      if (len > HELD_MAX) len = $urandom_range(0, HELD_MAX);
      if (kind < 70 && $urandom_range(0, 1)) press(KEY_STAR);
      if (kind < 35) begin
        enter_code(len);
        press(KEY_POUND);
      end else if (kind < 50) begin
        // one wrong digit at a random position
        bad_pos = (len == 0) ? 0 : $urandom_range(0, len - 1);
        for (i = 0; i < len; i++) begin
          d = sb.code_digit(i);
          if (i == bad_pos) begin
            do d = random_digit(); while (d == sb.code_digit(i));
          end
          press(d);
        end
        press(KEY_POUND);
      end else if (kind < 60) begin
        // right digits, one too few or one too many
        if (len == 0 || (len < HELD_MAX && $urandom_range(0, 1))) enter_code(len + 1);
        else enter_code(len - 1);
        press(KEY_POUND);
      end else if (kind < 70) begin
        // false start wiped by star, then the real entry
        repeat ($urandom_range(1, 5)) press(random_digit());
        press(KEY_STAR);
        enter_code(len);
        press(KEY_POUND);
      end else if (kind < 78) begin
        // run past the entry limit
        repeat ($urandom_range(HELD_MAX + 1, HELD_MAX + 3)) press(random_digit());
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_key(LINES_W'($urandom_range(0, 15)), LINES_W'($urandom_range(0, 15)));
        end
      end
    end
  endtask

  initial begin
    logic [79:0] code;

    keys.valid        = 1'b0;
    keys.column_lines = '1;
    keys.row_lines    = '1;
    cfg_wr_en         = 1'b0;
    cfg_index         = CFG_PASS_LOW;
    cfg_wdata         = '0;

    // single synchronous reset at the start
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed presses against the reset passcode 0 1 2 3 7 B
    send_key(4'hF, 4'hF);            // no line low at all
    send_key(4'h0, 4'h0);            // every line low, first wins
    press(4'd15);                    // highest key index
    press(KEY_STAR);
    enter_code(6);
    press(KEY_POUND);                // exact code
    press(4'd0); press(4'd1); press(4'd2); press(4'd3); press(4'd7); press(4'd10);
    press(KEY_POUND);                // last digit wrong
    press(KEY_POUND);                // empty entry against a six-digit code
    random_presses(100);

    // full-length passcode: a twenty-digit match, then one digit too many
    drain();
    code = random_code();
    program_code(code[63:0], {48'd0, code[79:64]}, 64'd20);
    press(KEY_STAR);
    enter_code(HELD_MAX);
    press(KEY_POUND);
    repeat (HELD_MAX + 1) press(random_digit());
    random_presses(80);

    // empty passcode, all bits of the low and high registers set
    drain();
    program_code('1, 64'hFFFF, 64'd0);
    press(KEY_STAR);
    press(KEY_POUND);
    random_presses(60);

    // length at the register maximum, beyond the twenty stored positions
    drain();
    program_code('0, '0, 64'd31);
    random_presses(60);

    // just past twenty, with junk above the high and length registers' widths
    drain();
    code = random_code();
    program_code(code[63:0], {$urandom, 16'($urandom), code[79:64]},
                 {$urandom, 27'($urandom), 5'd21});
    random_presses(40);

    // a stretch with no idling on either side
    drain();
    code = random_code();
    program_code(code[63:0], {48'd0, code[79:64]}, 64'($urandom_range(1, HELD_MAX)));
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    random_presses(60);

    // long receiver hold-off while keys keep coming, so the input stalls
    sink_idle_pct = 16;
    hold_off_req  = 1'b1;
    random_presses(30);
    src_idle_pct  = 16;
    random_presses(40);

    drain();
    if (sb.fails == 0 && sb.pending() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/kpl_pkg.sv
sv/kpl_if.sv
sv/kpl_front.sv
sv/kpl_fifo.sv
sv/kpl_back.sv
sv/keypad_passcode_lock_top.sv
dv/kpl_tb_pkg.sv
dv/tb_top.sv
